/* sv/bmrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrs_pkg
// Shared sizes, stack entry layout and controller command codes.
// ----------------------------------------------------------------------------
package bmrs_pkg;

  localparam int MAX_KEYS    = 1024;
  localparam int KEY_BITS    = 64;
  localparam int STACK_DEPTH = 128;

  localparam int KADDR_W = $clog2(MAX_KEYS);
  localparam int IDX_W   = KADDR_W + 1;
  localparam int SADDR_W = $clog2(STACK_DEPTH);
  localparam int TOP_W   = SADDR_W + 1;
  localparam int BIT_W   = 6;

  localparam logic [BIT_W-1:0] START_BIT_RST = 6'd63;
  localparam logic [63:0]      KEY_MASK      = 64'({64{1'b1}} >> (64 - KEY_BITS));

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [BIT_W-1:0] bit_no;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE   = 4'd0;
  localparam op_t OP_LOAD   = 4'd1;
  localparam op_t OP_READ   = 4'd2;
  localparam op_t OP_RDDATA = 4'd3;
  localparam op_t OP_INIT   = 4'd4;
  localparam op_t OP_POP    = 4'd5;
  localparam op_t OP_POPCHK = 4'd6;
  localparam op_t OP_PRD    = 4'd7;
  localparam op_t OP_PCHK   = 4'd8;
  localparam op_t OP_PSW1   = 4'd9;
  localparam op_t OP_PSW2   = 4'd10;
  localparam op_t OP_PUSH1  = 4'd11;
  localparam op_t OP_PUSH2  = 4'd12;
  localparam op_t OP_DONE   = 4'd13;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic read_hit;
    logic out_busy;
    logic range_bad;
    logic bit_clr;
    logic j_last;
    logic bit_zero;
    logic stack_empty;
  } status_t;

endpackage
`default_nettype wire

/* sv/bmrs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/bmrs_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrs_datapath
// Key store, range stack, set bookkeeping and output register.
// ----------------------------------------------------------------------------
module bmrs_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bmrs_pkg::cmd_t              cmd,
  output bmrs_pkg::status_t                status,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bmrs_pkg::BIT_W-1:0]  cfg_wr_data,
  input  wire logic [63:0]                 in_key_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [63:0]                      out_sorted_key,
  output logic                             out_last_out,
  output logic                             out_error_flag
);
  import bmrs_pkg::*;

  logic [BIT_W-1:0] start_bit_r;
  logic [IDX_W-1:0] count_r, count_nxt, rp_r, rp_nxt;
  logic             ovf_r, ovf_nxt, ready_r, ready_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt, dst_r, dst_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [63:0]      a_r, a_nxt;
  logic             oval_r, oval_nxt, olast_r, olast_nxt, oerr_r, oerr_nxt;
  logic [63:0]      okey_r, okey_nxt;

  logic               kwe;
  logic [KADDR_W-1:0] kwaddr, kraddr;
  logic [63:0]        kwdata, krdata;
  logic               swe;
  logic [SADDR_W-1:0] swaddr, sraddr;
  range_t             swdata, srdata;
  logic [RANGE_W-1:0] srdata_raw;

  logic [IDX_W-1:0] eff_cnt, rp_inc, top_m1_idx;
  logic             eff_ovf, read_hit, room;
  logic [TOP_W-1:0] top_m1;
  logic [BIT_W-1:0] top_bit;

  bmrs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_keys (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata),
    .raddr(kraddr), .rdata(krdata)
  );

  bmrs_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
    .raddr(sraddr), .rdata(srdata_raw)
  );

  assign srdata     = range_t'(srdata_raw);
  assign eff_cnt    = ready_r ? '0 : count_r;
  assign eff_ovf    = ready_r ? 1'b0 : ovf_r;
  assign rp_inc     = rp_r + 1'b1;
  assign read_hit   = ready_r && (rp_r < count_r);
  assign top_m1     = top_r - 1'b1;
  assign top_m1_idx = '0;
  assign room       = top_r < TOP_W'(STACK_DEPTH);
  assign top_bit    = ({1'b0, start_bit_r} > (BIT_W + 1)'(KEY_BITS - 1)) ?
                      BIT_W'(KEY_BITS - 1) : start_bit_r;

  always_comb begin
    status.read_hit    = read_hit;
    status.out_busy    = oval_r;
    status.range_bad   = (srdata.lo >= srdata.hi) || (srdata.hi >= count_r);
    status.bit_clr     = ~krdata[bit_r];
    status.j_last      = (j_r == hi_r);
    status.bit_zero    = (bit_r == '0);
    status.stack_empty = (top_r == '0);
  end

  always_comb begin
    count_nxt = count_r;
    rp_nxt    = rp_r;
    ovf_nxt   = ovf_r;
    ready_nxt = ready_r;
    top_nxt   = top_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    bit_nxt   = bit_r;
    j_nxt     = j_r;
    dst_nxt   = dst_r;
    a_nxt     = a_r;
    oval_nxt  = oval_r & out_stall;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;
    okey_nxt  = okey_r;
    kwe       = 1'b0;
    kwaddr    = j_r[KADDR_W-1:0];
    kwdata    = krdata;
    kraddr    = j_r[KADDR_W-1:0];
    swe       = 1'b0;
    swaddr    = top_r[SADDR_W-1:0];
    swdata    = '{lo: lo_r, hi: (dst_r - 1'b1), bit_no: (bit_r - 1'b1)};
    sraddr    = top_m1[SADDR_W-1:0];
    case (cmd.op)
      OP_LOAD: begin
        rp_nxt    = '0;
        ready_nxt = 1'b0;
        top_nxt   = '0;
        if (eff_cnt < IDX_W'(MAX_KEYS)) begin
          kwe       = 1'b1;
          kwaddr    = eff_cnt[KADDR_W-1:0];
          kwdata    = in_key_in & KEY_MASK;
          count_nxt = eff_cnt + 1'b1;
          ovf_nxt   = eff_ovf;
        end else begin
          count_nxt = eff_cnt;
          ovf_nxt   = 1'b1;
        end
      end
      OP_READ: begin
        kraddr = rp_r[KADDR_W-1:0];
        if (read_hit) begin
          olast_nxt = (rp_inc == count_r);
          oerr_nxt  = ovf_r;
          if (rp_inc >= count_r) begin
            count_nxt = '0;
            rp_nxt    = '0;
            ovf_nxt   = 1'b0;
            ready_nxt = 1'b0;
            top_nxt   = '0;
          end else begin
            rp_nxt = rp_inc;
          end
        end else begin
          oval_nxt  = 1'b1;
          okey_nxt  = '0;
          olast_nxt = 1'b0;
          oerr_nxt  = 1'b1;
        end
      end
      OP_RDDATA: begin
        oval_nxt = 1'b1;
        okey_nxt = krdata;
      end
      OP_INIT: begin
        top_nxt = '0;
        if (count_r >= IDX_W'(2)) begin
          swe     = 1'b1;
          swaddr  = '0;
          swdata  = '{lo: top_m1_idx, hi: (count_r - 1'b1), bit_no: top_bit};
          top_nxt = TOP_W'(1);
        end
      end
      OP_POP: begin
        top_nxt = top_m1;
      end
      OP_POPCHK: begin
        lo_nxt  = srdata.lo;
        hi_nxt  = srdata.hi;
        bit_nxt = srdata.bit_no;
        j_nxt   = srdata.lo;
        dst_nxt = srdata.lo;
      end
      OP_PRD: begin
        kraddr = j_r[KADDR_W-1:0];
      end
      OP_PCHK: begin
        if (~krdata[bit_r]) begin
          a_nxt  = krdata;
          kraddr = dst_r[KADDR_W-1:0];
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      OP_PSW1: begin
        kwe    = 1'b1;
        kwaddr = j_r[KADDR_W-1:0];
        kwdata = krdata;
      end
      OP_PSW2: begin
        kwe     = 1'b1;
        kwaddr  = dst_r[KADDR_W-1:0];
        kwdata  = a_r;
        dst_nxt = dst_r + 1'b1;
        j_nxt   = j_r + 1'b1;
      end
      OP_PUSH1: begin
        if ((dst_r > lo_r + 1'b1) && room) begin
          swe     = 1'b1;
          swdata  = '{lo: lo_r, hi: (dst_r - 1'b1), bit_no: (bit_r - 1'b1)};
          top_nxt = top_r + 1'b1;
        end
      end
      OP_PUSH2: begin
        if ((dst_r < hi_r) && room) begin
          swe     = 1'b1;
          swdata  = '{lo: dst_r, hi: hi_r, bit_no: (bit_r - 1'b1)};
          top_nxt = top_r + 1'b1;
        end
      end
      OP_DONE: begin
        rp_nxt    = '0;
        ready_nxt = (count_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_bit_r <= START_BIT_RST;
      count_r     <= '0;
      rp_r        <= '0;
      ovf_r       <= 1'b0;
      ready_r     <= 1'b0;
      top_r       <= '0;
      oval_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_bit_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      rp_r    <= rp_nxt;
      ovf_r   <= ovf_nxt;
      ready_r <= ready_nxt;
      top_r   <= top_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    bit_r   <= bit_nxt;
    j_r     <= j_nxt;
    dst_r   <= dst_nxt;
    a_r     <= a_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    okey_r  <= okey_nxt;
  end

  assign out_valid      = oval_r;
  assign out_sorted_key = okey_r;
  assign out_last_out   = olast_r;
  assign out_error_flag = oerr_r;

endmodule
`default_nettype wire

/* sv/bmrs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrs_ctrl
// Sequencer for load, read and the in-place partition sort.
// ----------------------------------------------------------------------------
module bmrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_func,
  input  wire logic              in_last_key,
  input  wire bmrs_pkg::status_t status,
  output bmrs_pkg::cmd_t         cmd
);
  import bmrs_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDW    = 4'd1;
  localparam logic [3:0] ST_INIT   = 4'd2;
  localparam logic [3:0] ST_POP    = 4'd3;
  localparam logic [3:0] ST_POPCHK = 4'd4;
  localparam logic [3:0] ST_PRD    = 4'd5;
  localparam logic [3:0] ST_PCHK   = 4'd6;
  localparam logic [3:0] ST_PSW1   = 4'd7;
  localparam logic [3:0] ST_PSW2   = 4'd8;
  localparam logic [3:0] ST_PUSH1  = 4'd9;
  localparam logic [3:0] ST_PUSH2  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       accept;
  logic [3:0] scan_end;

  assign in_stall = (state_r != ST_IDLE) || status.out_busy;
  assign accept   = in_valid && !in_stall;
  assign scan_end = status.bit_zero ? ST_POP : ST_PUSH1;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !in_func) begin
          cmd.op = OP_LOAD;
          if (in_last_key) begin
            state_nxt = ST_INIT;
          end
        end else if (accept) begin
          cmd.op = OP_READ;
          if (status.read_hit) begin
            state_nxt = ST_RDW;
          end
        end
      end
      ST_RDW: begin
        cmd.op    = OP_RDDATA;
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (status.stack_empty) begin
          cmd.op    = OP_DONE;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = ST_POPCHK;
        end
      end
      ST_POPCHK: begin
        cmd.op    = OP_POPCHK;
        state_nxt = status.range_bad ? ST_POP : ST_PRD;
      end
      ST_PRD: begin
        cmd.op    = OP_PRD;
        state_nxt = ST_PCHK;
      end
      ST_PCHK: begin
        cmd.op = OP_PCHK;
        if (status.bit_clr) begin
          state_nxt = ST_PSW1;
        end else begin
          state_nxt = status.j_last ? scan_end : ST_PRD;
        end
      end
      ST_PSW1: begin
        cmd.op    = OP_PSW1;
        state_nxt = ST_PSW2;
      end
      ST_PSW2: begin
        cmd.op    = OP_PSW2;
        state_nxt = status.j_last ? scan_end : ST_PRD;
      end
      ST_PUSH1: begin
        cmd.op    = OP_PUSH1;
        state_nxt = ST_PUSH2;
      end
      ST_PUSH2: begin
        cmd.op    = OP_PUSH2;
        state_nxt = ST_POP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/binary_msd_radix_sort.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_msd_radix_sort
// Loads 64-bit keys, sorts them by binary MSD partitioning, reads them back.
// ----------------------------------------------------------------------------
// Load: one transfer per cycle while in_stall is low, no result.
// Read: a miss shows its error result in the next cycle; a hit first reads the key
//   store's registered port, then loads the output register; one read in flight at a time.
// Sort after the last key: input stalls while each range is scanned; every key takes a
//   read (PRD) and a check (PCHK), every swap adds writes PSW1 and PSW2 on the key store.
// Reset (rst_n low, synchronous) empties the set and sets start_bit to 63.
module binary_msd_radix_sort (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bmrs_pkg::BIT_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [63:0]                 in_key_in,
  input  wire logic                        in_last_key,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [63:0]                      out_sorted_key,
  output logic                             out_last_out,
  output logic                             out_error_flag
);
  import bmrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence loads, reads and each partition pass; hold input while busy.
  bmrs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_last_key (in_last_key),
    .status      (status),
    .cmd         (cmd)
  );

  // Keep keys, range stack and the output register that parts the result side.
  bmrs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_key_in      (in_key_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sorted_key (out_sorted_key),
    .out_last_out   (out_last_out),
    .out_error_flag (out_error_flag)
  );

endmodule
`default_nettype wire

/* test/binary_msd_radix_sort_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_msd_radix_sort_tb
// Self-checking bench for the radix sort block: loads key sets, reads them
// back and compares every read against a software sorter kept in step.
// ----------------------------------------------------------------------------
module binary_msd_radix_sort_tb;
  import bmrs_pkg::*;

  localparam logic OP_LOAD_KEY = 1'b0;
  localparam logic OP_READ_KEY = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [63:0] key;
    logic        last;
    logic        err;
  } sort_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [BIT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [63:0] in_key_in = '0;
  logic in_last_key = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_sorted_key;
  logic out_last_out;
  logic out_error_flag;

  binary_msd_radix_sort uut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_key_in(in_key_in), .in_last_key(in_last_key), .out_valid(out_valid),
    .out_stall(out_stall), .out_sorted_key(out_sorted_key),
    .out_last_out(out_last_out), .out_error_flag(out_error_flag)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: a copy of the block's key store and set bookkeeping.
  logic [63:0] shadow_keys [MAX_KEYS];
  int unsigned shadow_count, shadow_rd;
  bit          shadow_ovf, shadow_ready;
  logic [5:0]  shadow_start_bit = START_BIT_RST;

  // start_bit settings walked by the random part, extremes included.
  logic [5:0]  start_bits [5] = '{6'd63, 6'd0, 6'd31, 6'd3, 6'd63};

  sort_out_t pending_reads[$];
  int  fail_count, read_count, load_count, set_count;
  bit  quiet_phase;
  longint cycle_count;

  // Partition one range on a bit, keys with the bit clear go to the front.
  function automatic int unsigned partition_on_bit(int unsigned lo, int unsigned hi,
                                                   int unsigned b);
    int unsigned dst;
    logic [63:0] t;
    dst = lo;
    for (int unsigned j = lo; j <= hi; j++) begin
      if (shadow_keys[j][b] == 1'b0) begin
        t = shadow_keys[j];
        shadow_keys[j] = shadow_keys[dst];
        shadow_keys[dst] = t;
        dst++;
      end
    end
    return dst;
  endfunction

  // Binary quicksort with an explicit range stack, same pop/push order.
  function automatic void sort_shadow_set();
    int unsigned slo[$], shi[$], sbit[$];
    int unsigned lo, hi, b, p;
    if (shadow_count >= 2) begin
      slo.push_back(0); shi.push_back(shadow_count - 1); sbit.push_back(shadow_start_bit);
    end
    while (slo.size() > 0) begin
      lo = slo.pop_back(); hi = shi.pop_back(); b = sbit.pop_back();
      if (lo >= hi) continue;
      p = partition_on_bit(lo, hi, b);
      if (b == 0) continue;
      if (p > lo + 1) begin
        slo.push_back(lo); shi.push_back(p - 1); sbit.push_back(b - 1);
      end
      if (p < hi) begin
        slo.push_back(p); shi.push_back(hi); sbit.push_back(b - 1);
      end
    end
  endfunction

  function automatic void clear_shadow_set();
    shadow_count = 0; shadow_rd = 0; shadow_ovf = 0; shadow_ready = 0;
  endfunction

  // Advance the predictor by one accepted transfer; queue the read result.
  function automatic void predict_transfer(logic func, logic [63:0] key, logic last);
    sort_out_t r;
    if (func == OP_LOAD_KEY) begin
      if (shadow_ready) clear_shadow_set();
      if (shadow_count < MAX_KEYS) begin
        shadow_keys[shadow_count] = key & KEY_MASK;
        shadow_count++;
      end else shadow_ovf = 1;
      if (last) begin
        sort_shadow_set();
        shadow_rd = 0;
        shadow_ready = shadow_count > 0;
        set_count++;
      end
      load_count++;
    end else begin
      if (!shadow_ready || shadow_rd >= shadow_count) begin
        r = '{key: 64'd0, last: 1'b0, err: 1'b1};
      end else begin
        r.key = shadow_keys[shadow_rd];
        r.last = (shadow_rd + 1 == shadow_count);
        r.err = shadow_ovf;
        shadow_rd++;
        if (shadow_rd >= shadow_count) clear_shadow_set();
      end
      pending_reads.push_back(r);
      read_count++;
    end
  endfunction

  // Check results and the cycle limit on every rising edge.
  always @(posedge clk) begin
    sort_out_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("result with no read pending: key %h", out_sorted_key);
        fail_count++;
      end else begin
        e = pending_reads.pop_front();
        if (out_sorted_key !== e.key) begin
          $error("sorted_key exp %h got %h", e.key, out_sorted_key); fail_count++;
        end
        if (out_last_out !== e.last) begin
          $error("last_out exp %b got %b", e.last, out_last_out); fail_count++;
        end
        if (out_error_flag !== e.err) begin
          $error("error_flag exp %b got %b", e.err, out_error_flag); fail_count++;
        end
      end
    end
  end

  // Receiver: stall in random bursts, none in the quiet phase.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Drive one transfer and hold it until accepted; optional idle burst first.
  task automatic send_item(logic func, logic [63:0] key, logic last);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_key_in <= key;
    in_last_key <= last;
    do @(posedge clk); while (in_stall);
    predict_transfer(func, key, last);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_bit(logic [5:0] sb);
    go_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_start_bit = sb;
  endtask

  function automatic logic [63:0] rand_key(int unsigned style);
    logic [63:0] k;
    k = {$urandom, $urandom};
    case (style)
      0: k = k & 64'hF;                // dense duplicates
      1: k = ~k;
      2: k = k >> $urandom_range(0, 63);
      default: ;
    endcase
    return k;
  endfunction

  // Load a set of n keys then read it back, reading one extra sometimes.
  task automatic run_set(int unsigned n);
    int unsigned style;
    style = $urandom_range(0, 3);
    for (int unsigned i = 0; i < n; i++)
      send_item(OP_LOAD_KEY, rand_key(style), i == n - 1);
    for (int unsigned i = 0; i < n; i++)
      send_item(OP_READ_KEY, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) == 0) send_item(OP_READ_KEY, '0, 1'b0);
  endtask

  // Directed table: func, key, last, whether a typed result applies, result.
  typedef struct {
    logic        func;
    logic [63:0] key;
    logic        last;
    bit          typed;
    sort_out_t   res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h0, 1'b0, 1'b1}},          // read when empty
    '{OP_LOAD_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h0, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h8000_0000_0000_0000, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h0000_0000_0000_0001, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h0, 1'b1, 0, '0},                           // duplicate, last
    '{OP_READ_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1, '{64'h0, 1'b0, 1'b0}},
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h0, 1'b0, 1'b0}},
    '{OP_READ_KEY, 64'h0, 1'b0, 0, '0},
    '{OP_READ_KEY, 64'h0, 1'b0, 0, '0},
    '{OP_READ_KEY, 64'h0, 1'b0, 0, '0},
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}},
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h0, 1'b0, 1'b1}},          // past end of set
    '{OP_LOAD_KEY, 64'h1234_5678_9ABC_DEF0, 1'b1, 0, '0},          // single-key set
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0}},
    '{OP_LOAD_KEY, 64'h5, 1'b0, 0, '0},
    '{OP_LOAD_KEY, 64'h3, 1'b1, 0, '0},
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h3, 1'b0, 1'b0}},
    '{OP_LOAD_KEY, 64'h9, 1'b1, 0, '0},                            // discards pending set
    '{OP_READ_KEY, 64'h0, 1'b0, 1, '{64'h9, 1'b1, 1'b0}}
  };

  initial begin
    sort_out_t typed_res;
    clear_shadow_set();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].func, dir_rows[i].key, dir_rows[i].last);
      // Override the predictor with the hand-typed value where one is given.
      if (dir_rows[i].typed && dir_rows[i].func == OP_READ_KEY) begin
        typed_res = pending_reads.pop_back();
        if (typed_res !== dir_rows[i].res)
          $display("note: predictor disagrees with table row %0d", i);
        pending_reads.push_back(dir_rows[i].res);
      end
    end

    // Overflow set: MAX_KEYS+2 loads, every read flags error.
    write_start_bit(6'd9);
    for (int unsigned i = 0; i < MAX_KEYS + 2; i++)
      send_item(OP_LOAD_KEY, {$urandom, $urandom} & 64'h3FF, i == MAX_KEYS + 1);
    for (int unsigned i = 0; i < 20; i++) send_item(OP_READ_KEY, '0, 1'b0);
    send_item(OP_LOAD_KEY, 64'h1, 1'b1);               // discard, start fresh
    send_item(OP_READ_KEY, '0, 1'b0);

    // Random sets across several start_bit settings, extremes included.
    foreach (start_bits[s]) begin
      write_start_bit(start_bits[s]);
      for (int k = 0; k < 4; k++) run_set($urandom_range(1, 12));
      if (s == 2) go_idle();                            // drain before continuing
    end

    quiet_phase = 1;
    for (int k = 0; k < 4; k++) run_set($urandom_range(2, 10));
    go_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d loads, %0d reads over %0d sorted sets.",
             load_count, read_count, set_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
